FILE: design/block_average_pixelation_macros.svh
// Assertion macros shared by the block average pixelation modules.
`ifndef BLOCK_AVERAGE_PIXELATION_MACROS_SVH
`define BLOCK_AVERAGE_PIXELATION_MACROS_SVH

`ifndef ASSERT_OFF
`define BAP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("block_average_pixelation assertion failed");
`define BAP_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("block_average_pixelation forbidden condition");
`else
`define BAP_ASSERT(lbl, clk, rst_n, prop)
`define BAP_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: design/bap_pkg.sv
// Shared types and constants of the block average pixelation block.
package bap_pkg;

    localparam int TILE_W   = 7;
    localparam int DIM_W    = 12;
    localparam int POS_W    = 11;
    localparam int CIT_W    = 6;
    localparam int SUM_W    = 20;
    localparam int CNT_W    = 13;
    localparam int PIX_W    = 8;
    localparam int NCH      = 4;
    localparam int MAX_TILE = 64;
    localparam int MAX_DIM  = 2048;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int STEP_W   = $clog2(SUM_W);
    localparam int IDX_W    = 2;

    localparam logic [TILE_W-1:0] RESET_TILE   = TILE_W'(10);
    localparam logic [DIM_W-1:0]  RESET_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0]  RESET_HEIGHT = DIM_W'(480);

    typedef enum logic [IDX_W-1:0] {
        REG_TILE_SIZE    = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } t_reg_idx;

    typedef enum logic {
        FR_IDLE,
        FR_ACC
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } t_back_state;

    // One finished tile on its way to the divider
    typedef struct packed {
        logic [POS_W-1:0]            tile_col;
        logic [POS_W-1:0]            tile_row;
        logic [NCH-1:0][SUM_W-1:0]   sum;
        logic [CNT_W-1:0]            count;
        logic                        frame_done;
    } t_tile_job;

endpackage

FILE: design/bap_front.sv
// Front end: position tracking, column sum memory and tile completion detect.
module bap_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bap_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [bap_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_pix_valid,
    output logic                          o_pix_ready,
    input  logic [bap_pkg::NCH*bap_pkg::PIX_W-1:0] i_pix,
    input  logic                          i_q_full,
    output logic                          o_push,
    output bap_pkg::t_tile_job            o_job
);
    import bap_pkg::*;
    `include "block_average_pixelation_macros.svh"

    t_front_state r_state, n_state;

    logic [TILE_W-1:0] r_tile;
    logic [DIM_W-1:0]  r_width, r_height;
    logic [POS_W-1:0]  r_px_col, r_px_row, r_tcol, r_trow;
    logic [CIT_W-1:0]  r_cit, r_rit;
    logic [POS_W-1:0]  n_px_col, n_px_row, n_tcol, n_trow;
    logic [CIT_W-1:0]  n_cit, n_rit;

    logic [TILE_W-1:0] ts_eff;
    logic [DIM_W-1:0]  w_eff, h_eff;
    logic row_end, col_last, frame_end, tile_right, tile_bottom, accept;

    // Item captured at the accept edge
    logic [NCH*PIX_W-1:0] r_px;
    logic [POS_W-1:0]     r_idx, r_jcol, r_jrow;
    logic                 r_first, r_emit, r_fend;
    logic [CNT_W-1:0]     r_count;

    logic [NCH*SUM_W-1:0] mem [MAX_DIM];
    logic [NCH*SUM_W-1:0] r_rd;
    logic [NCH-1:0][SUM_W-1:0] sums;

    // Clamped register views
    always_comb begin
        if (r_tile == '0) ts_eff = TILE_W'(1);
        else if (r_tile > TILE_W'(MAX_TILE)) ts_eff = TILE_W'(MAX_TILE);
        else ts_eff = r_tile;
        if (r_width == '0) w_eff = DIM_W'(1);
        else if (r_width > DIM_W'(MAX_DIM)) w_eff = DIM_W'(MAX_DIM);
        else w_eff = r_width;
        if (r_height == '0) h_eff = DIM_W'(1);
        else if (r_height > DIM_W'(MAX_DIM)) h_eff = DIM_W'(MAX_DIM);
        else h_eff = r_height;
    end

    // Position classification
    always_comb begin
        row_end     = ({1'b0, r_px_col} + DIM_W'(1)) >= w_eff;
        col_last    = ({1'b0, r_px_row} + DIM_W'(1)) >= h_eff;
        frame_end   = row_end && col_last;
        tile_right  = row_end || (({1'b0, r_cit} + TILE_W'(1)) >= ts_eff);
        tile_bottom = col_last || (({1'b0, r_rit} + TILE_W'(1)) >= ts_eff);
    end

    // Next position counters
    always_comb begin
        n_px_col = r_px_col + POS_W'(1);
        n_px_row = r_px_row;
        n_tcol   = r_tcol;
        n_trow   = r_trow;
        n_cit    = r_cit + CIT_W'(1);
        n_rit    = r_rit;
        if (tile_right) begin
            n_cit  = '0;
            n_tcol = r_tcol + POS_W'(1);
        end
        if (row_end) begin
            n_px_col = '0;
            n_cit    = '0;
            n_tcol   = '0;
            n_px_row = r_px_row + POS_W'(1);
            if (tile_bottom) begin
                n_rit  = '0;
                n_trow = r_trow + POS_W'(1);
            end else begin
                n_rit = r_rit + CIT_W'(1);
            end
            if (frame_end) begin
                n_px_row = '0;
                n_rit    = '0;
                n_trow   = '0;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_IDLE: if (accept) n_state = FR_ACC;
            FR_ACC:  n_state = FR_IDLE;
            default: n_state = FR_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pix_ready = 1'b0;
        o_push      = 1'b0;
        case (r_state)
            FR_IDLE: o_pix_ready = !i_q_full;
            FR_ACC:  o_push = r_emit;
            default: o_pix_ready = 1'b0;
        endcase
    end

    assign accept = i_pix_valid && o_pix_ready;

    // Control registers and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FR_IDLE;
            r_tile   <= RESET_TILE;
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
            r_px_col <= '0;
            r_px_row <= '0;
            r_tcol   <= '0;
            r_trow   <= '0;
            r_cit    <= '0;
            r_rit    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en && i_cfg_index <= IDX_W'(REG_IMAGE_HEIGHT)) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_TILE_SIZE:    r_tile   <= i_cfg_data[TILE_W-1:0];
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default:          r_tile   <= r_tile;
                endcase
                r_px_col <= '0;
                r_px_row <= '0;
                r_tcol   <= '0;
                r_trow   <= '0;
                r_cit    <= '0;
                r_rit    <= '0;
            end else if (accept) begin
                r_px_col <= n_px_col;
                r_px_row <= n_px_row;
                r_tcol   <= n_tcol;
                r_trow   <= n_trow;
                r_cit    <= n_cit;
                r_rit    <= n_rit;
            end
        end
    end

    // Capture of the accepted pixel and its tile context
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px    <= i_pix;
            r_idx   <= r_tcol;
            r_first <= (r_cit == '0) && (r_rit == '0);
            r_emit  <= tile_right && tile_bottom;
            r_count <= CNT_W'(({1'b0, r_cit} + TILE_W'(1)) * ({1'b0, r_rit} + TILE_W'(1)));
            r_jcol  <= r_tcol;
            r_jrow  <= r_trow;
            r_fend  <= frame_end;
        end
    end

    // Column sum update
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            if (r_first)
                sums[c] = SUM_W'(r_px[c*PIX_W +: PIX_W]);
            else
                sums[c] = r_rd[c*SUM_W +: SUM_W] + SUM_W'(r_px[c*PIX_W +: PIX_W]);
        end
    end

    // Column sum memory: read on accept, written back in the following cycle
    always_ff @(posedge i_clk) begin
        if (accept) r_rd <= mem[r_tcol];
        if (r_state == FR_ACC) mem[r_idx] <= sums;
    end

    always_comb begin
        o_job.tile_col   = r_jcol;
        o_job.tile_row   = r_jrow;
        o_job.sum        = sums;
        o_job.count      = r_count;
        o_job.frame_done = r_fend;
    end

    `BAP_ASSERT(a_acc_after_accept, i_clk, i_rst_n, accept |=> r_state == FR_ACC)
    `BAP_ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, o_push && i_q_full)
endmodule

FILE: design/bap_queue.sv
// Short queue of finished tiles between the front end and the divider.
module bap_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bap_pkg::t_tile_job i_job,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_full,
    output bap_pkg::t_tile_job o_job
);
    import bap_pkg::*;

    t_tile_job           r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QPTR_W:0]     r_cnt;

    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == (QPTR_W+1)'(QDEPTH);
    assign o_job   = r_mem[r_rp];

    // Pointer and fill tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QPTR_W'(1);
            if (i_pop)  r_rp <= r_rp + QPTR_W'(1);
            if (i_push && !i_pop) r_cnt <= r_cnt + (QPTR_W+1)'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end
endmodule

FILE: design/bap_back.sv
// Back end: restoring division of the four tile sums and the output register.
module bap_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  bap_pkg::t_tile_job i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [bap_pkg::POS_W-1:0]            o_tile_col,
    output logic [bap_pkg::POS_W-1:0]            o_tile_row,
    output logic [bap_pkg::NCH-1:0][bap_pkg::PIX_W-1:0] o_mean,
    output logic               o_frame_done
);
    import bap_pkg::*;
    `include "block_average_pixelation_macros.svh"

    t_back_state r_state, n_state;

    logic [NCH-1:0][SUM_W-1:0] r_quo, n_quo;
    logic [NCH-1:0][CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;
    logic [POS_W-1:0]  r_col, r_row;
    logic              r_fd;
    logic              out_free, load_out;
    logic [CNT_W:0]    sh;

    assign out_free = !o_valid || i_ready;

    // One restoring step per channel
    always_comb begin
        sh = '0;
        for (int c = 0; c < NCH; c++) begin
            sh = {r_rem[c], r_quo[c][SUM_W-1]};
            n_quo[c] = {r_quo[c][SUM_W-2:0], 1'b0};
            if (sh >= {1'b0, r_div}) begin
                n_rem[c] = CNT_W'(sh - {1'b0, r_div});
                n_quo[c][0] = 1'b1;
            end else begin
                n_rem[c] = sh[CNT_W-1:0];
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (i_q_valid) n_state = BK_DIV;
            BK_DIV:  if (r_step == STEP_W'(SUM_W-1)) n_state = BK_HOLD;
            BK_HOLD: if (out_free) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            BK_IDLE: o_pop = i_q_valid;
            BK_HOLD: load_out = out_free;
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end

    // Divider datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_quo  <= i_job.sum;
            r_rem  <= '0;
            r_div  <= i_job.count;
            r_step <= '0;
            r_col  <= i_job.tile_col;
            r_row  <= i_job.tile_row;
            r_fd   <= i_job.frame_done;
        end else if (r_state == BK_DIV) begin
            r_quo  <= n_quo;
            r_rem  <= n_rem;
            r_step <= r_step + STEP_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_tile_col   <= r_col;
            o_tile_row   <= r_row;
            o_frame_done <= r_fd;
            for (int c = 0; c < NCH; c++) o_mean[c] <= r_quo[c][PIX_W-1:0];
        end
    end

    `BAP_ASSERT(a_div_nonzero, i_clk, i_rst_n, r_state == BK_DIV |-> r_div != '0)
    `BAP_ASSERT(a_div_ends, i_clk, i_rst_n, (r_state == BK_DIV && r_step == STEP_W'(SUM_W-1)) |=> r_state == BK_HOLD)
endmodule

FILE: design/block_average_pixelation.sv
// Block average pixelation top level: RGBA pixel stream in, tile means out.
// In the front end each pixel has a read of its tile column's running
// sums from the 2048-entry sum memory and then a write-back, and the
// input takes a new pixel only after that write-back. A finished
// tile goes through a two-entry queue to a restoring divider that works
// all four channels in parallel, one quotient bit a cycle for the 20-bit
// sums, between a load from the queue and the hand-over to the output
// register; the back end takes a new tile only once the last one has gone
// to the output register. With small tiles the queue fills and the input
// stalls to the divider's pace; a stalled result output holds the divider
// and, through the queue, the input too. The sum memory needs no clearing
// after reset; any register write restarts the frame at its first pixel.
module block_average_pixelation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [bap_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [bap_pkg::DIM_W-1:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // tile_col, tile_row, mean r/g/b/a, zero pad
    output logic        m_axis_tlast    // frame_done
);
    import bap_pkg::*;

    t_tile_job f_job, q_job;
    logic push, pop, q_valid, q_full;
    logic [POS_W-1:0] tcol, trow;
    logic [NCH-1:0][PIX_W-1:0] mean;

    bap_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix_valid (s_axis_tvalid),
        .o_pix_ready (s_axis_tready),
        .i_pix       (s_axis_tdata),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (f_job)
    );

    bap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (q_job)
    );

    bap_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_job        (q_job),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_tile_col   (tcol),
        .o_tile_row   (trow),
        .o_mean       (mean),
        .o_frame_done (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, mean[3], mean[2], mean[1], mean[0], trow, tcol};
endmodule
